>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante implies cons in the same cycle
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// cond never holds
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/rwta_pkg.sv
// Package for the wall texel address pipeline: constants, types, cosine ROM.
// No dependencies.
`default_nettype none
package rwta_pkg;

  localparam int TILE_W      = 6;               // log2 of tile size
  localparam int COS_W       = 10;              // log2 of quarter-wave entries
  localparam int COS_ENTRIES = 1 << COS_W;
  localparam int DIST_W      = 24;
  localparam int H_W         = 16;
  localparam int NUM_W       = 16 + TILE_W + 8; // projection * tile * 256
  localparam int DIV_BITS    = H_W;
  localparam int ROW_BITS    = TILE_W;
  localparam int LATENCY     = 3 + 1 + DIV_BITS + 1 + 1 + ROW_BITS + 1;

  localparam logic [1:0] FACE_NORTH = 2'd0;
  localparam logic [1:0] FACE_SOUTH = 2'd1;
  localparam logic [1:0] FACE_WEST  = 2'd2;
  localparam logic [1:0] FACE_EAST  = 2'd3;

  localparam logic [1:0] REG_PROJ  = 2'd0;
  localparam logic [1:0] REG_HALF  = 2'd1;
  localparam logic [1:0] REG_SCRH  = 2'd2;

  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint Q30_HALF_PI = 64'sd1686629713;

  typedef logic [16:0] cos_rom_t [COS_ENTRIES+1];

  typedef struct packed {
    logic [1:0]        face;
    logic [TILE_W-1:0] col;
    logic [11:0]       line;
    logic [DIST_W-1:0] cdist;
  } pay_t;

  // cos(pi/2 * i / COS_ENTRIES), Q16, from a Q30 Taylor series
  function automatic cos_rom_t cos_rom_init();
    cos_rom_t rom;
    longint unsigned x, x2, t;
    longint s, r;
    for (int i = 0; i <= COS_ENTRIES; i++) begin
      x  = longint'(Q30_HALF_PI) * longint'(i) / COS_ENTRIES;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      s  = Q30_ONE;
      t = ((t * x2) >> 30) / 2;   s = s - longint'(t);
      t = ((t * x2) >> 30) / 12;  s = s + longint'(t);
      t = ((t * x2) >> 30) / 30;  s = s - longint'(t);
      t = ((t * x2) >> 30) / 56;  s = s + longint'(t);
      t = ((t * x2) >> 30) / 90;  s = s - longint'(t);
      t = ((t * x2) >> 30) / 132; s = s + longint'(t);
      t = ((t * x2) >> 30) / 182; s = s - longint'(t);
      t = ((t * x2) >> 30) / 240; s = s + longint'(t);
      t = ((t * x2) >> 30) / 306; s = s - longint'(t);
      t = ((t * x2) >> 30) / 380; s = s + longint'(t);
      t = ((t * x2) >> 30) / 462; s = s - longint'(t);
      t = ((t * x2) >> 30) / 552; s = s + longint'(t);
      if (s < 0) s = 0;
      r = (s + 8192) >>> 14;
      if (r > 65536) r = 65536;
      rom[i] = r[16:0];
    end
    return rom;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/raycast_wall_texel_address.sv
// Top level of the ray-cast wall texel address pipeline.
// Depends on rwta_pkg and assert_macros.svh.
//
//  channel  | handshake              | beat
//  ---------+------------------------+-------------------------------------
//  input    | start_i && !busy_o     | ray length, angles, hit, flags, line
//  result   | valid_o (one cycle)    | in_wall, face, texel col/row, dist
//  config   | APB psel/penable/pwrite| projection, half height, height
//
// One beat enters per cycle; busy_o is tied low.
// The pipeline's length comes chiefly from the 16 one-bit stages of the
// height divider and the 6 one-bit stages of the texel row divider.
// Reset clears the valid bits of every stage and loads register defaults.
// The result side cannot stall, so nothing inside ever waits.
`default_nettype none
`include "assert_macros.svh"
module raycast_wall_texel_address import rwta_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [23:0]       ray_length_i,
  input  wire logic [11:0]       ray_angle_i,
  input  wire logic [11:0]       player_angle_i,
  input  wire logic [15:0]       hit_x_i,
  input  wire logic [15:0]       hit_y_i,
  input  wire logic              hit_vertical_i,
  input  wire logic              facing_left_i,
  input  wire logic              facing_up_i,
  input  wire logic [11:0]       screen_line_i,
  output logic                   valid_o,
  output logic                   in_wall_o,
  output logic [1:0]             wall_face_o,
  output logic [5:0]             texel_column_o,
  output logic [5:0]             texel_row_o,
  output logic [23:0]            corrected_distance_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam cos_rom_t COS_ROM = cos_rom_init();

  // ---------------- configuration registers ----------------
  logic [15:0] proj_q;
  logic [10:0] shh_q;
  logic [11:0] sh_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign busy_o = 1'b0;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proj_q <= 16'd554;
      shh_q  <= 11'd240;
      sh_q   <= 12'd480;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_PROJ: proj_q <= pwdata[15:0];
        REG_HALF: shh_q  <= pwdata[10:0];
        REG_SCRH: sh_q   <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_PROJ: prdata = {16'd0, proj_q};
      REG_HALF: prdata = {21'd0, shh_q};
      REG_SCRH: prdata = {20'd0, sh_q};
      default:  prdata = 32'd0;
    endcase
  end

  // ---------------- S1: angle difference, table index, face, column ----------------
  logic                  s1_vld_q;
  logic [COS_W:0]        s1_idx_q;
  logic                  s1_neg_q;
  logic [23:0]           s1_len_q;
  pay_t                  s1_pay_q;
  logic [11:0]           diff;
  logic [1:0]            quad;
  logic [1:0]            face_d;
  logic [15:0]           hit_sel;

  assign diff    = ray_angle_i - player_angle_i;
  assign quad    = diff[11:10];
  assign hit_sel = hit_vertical_i ? hit_y_i : hit_x_i;

  always_comb begin
    if (hit_vertical_i) face_d = facing_left_i ? FACE_WEST : FACE_EAST;
    else                face_d = facing_up_i ? FACE_NORTH : FACE_SOUTH;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else         s1_vld_q <= start_i;
  end

  // quadrants 1 and 3 read the table mirrored; 1 and 2 have negative cosine
  always_ff @(posedge clk_i) begin
    s1_idx_q <= quad[0] ? ((COS_W+1)'(COS_ENTRIES) - {1'b0, diff[9:0]})
                        : {1'b0, diff[9:0]};
    s1_neg_q       <= quad[0] ^ quad[1];
    s1_len_q       <= ray_length_i;
    s1_pay_q.face  <= face_d;
    s1_pay_q.col   <= hit_sel[TILE_W-1:0];
    s1_pay_q.line  <= screen_line_i;
    s1_pay_q.cdist <= '0;
  end

  // ---------------- S2: cosine ROM read ----------------
  logic        s2_vld_q;
  logic [16:0] s2_cos_q;
  logic        s2_neg_q;
  logic [23:0] s2_len_q;
  pay_t        s2_pay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_vld_q <= 1'b0;
    else         s2_vld_q <= s1_vld_q;
  end

  always_ff @(posedge clk_i) begin
    s2_cos_q <= COS_ROM[s1_idx_q];
    s2_neg_q <= s1_neg_q;
    s2_len_q <= s1_len_q;
    s2_pay_q <= s1_pay_q;
  end

  // ---------------- S3: fisheye correction multiply ----------------
  logic        s3_vld_q;
  pay_t        s3_pay_q;
  logic [40:0] prod;

  assign prod = {17'd0, s2_len_q} * {24'd0, s2_cos_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_vld_q <= 1'b0;
    else         s3_vld_q <= s2_vld_q;
  end

  always_ff @(posedge clk_i) begin
    s3_pay_q.face  <= s2_pay_q.face;
    s3_pay_q.col   <= s2_pay_q.col;
    s3_pay_q.line  <= s2_pay_q.line;
    s3_pay_q.cdist <= s2_neg_q ? '0 : prod[DIST_W+15:16];
  end

  // ---------------- height divider: TILE*proj*256 / dist ----------------
  typedef struct packed {
    pay_t             pay;
    logic             ovf;
    logic [NUM_W-1:0] rem;
    logic [H_W-1:0]   quot;
  } div_t;

  logic [DIV_BITS:0] div_vld_q;
  div_t              div_q [DIV_BITS+1];
  logic [NUM_W-1:0]  num;

  assign num = {proj_q, (TILE_W+8)'(0)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) div_vld_q <= '0;
    else         div_vld_q <= {div_vld_q[DIV_BITS-1:0], s3_vld_q};
  end

  // quotient past 16 bits, or a zero distance, saturates the height
  always_ff @(posedge clk_i) begin
    div_q[0].pay  <= s3_pay_q;
    div_q[0].ovf  <= (s3_pay_q.cdist == '0) ||
                     ({(DIST_W+H_W-NUM_W)'(0), num} >= {s3_pay_q.cdist, (H_W)'(0)});
    div_q[0].rem  <= num;
    div_q[0].quot <= '0;
  end

  for (genvar g = 1; g <= DIV_BITS; g++) begin : g_div
    localparam int K = DIV_BITS - g;
    logic [DIST_W+H_W-1:0] sub;
    logic [DIST_W+H_W-1:0] rem_x;
    logic                  ge;
    assign sub   = {(H_W)'(0), div_q[g-1].pay.cdist} << K;
    assign rem_x = {(DIST_W+H_W-NUM_W)'(0), div_q[g-1].rem};
    assign ge    = rem_x >= sub;
    always_ff @(posedge clk_i) begin
      div_q[g].pay  <= div_q[g-1].pay;
      div_q[g].ovf  <= div_q[g-1].ovf;
      div_q[g].rem  <= ge ? NUM_W'(rem_x - sub) : div_q[g-1].rem;
      div_q[g].quot <= div_q[g-1].quot | (ge ? (H_W)'(1) << K : '0);
    end
  end

  // ---------------- span stage: clamp wall span, offset below top ----------------
  logic           sp_vld_q;
  pay_t           sp_pay_q;
  logic [H_W-1:0] sp_h_q;
  logic           sp_in_q;
  logic [17:0]    sp_dft_q;
  logic [H_W-1:0] h;
  logic [14:0]    half;
  logic [15:0]    top;
  logic [15:0]    bot;
  logic [15:0]    sum_hb;

  assign h      = div_q[DIV_BITS].ovf ? '1 : div_q[DIV_BITS].quot;
  assign half   = h[H_W-1:1];
  assign top    = ({5'd0, shh_q} > {1'b0, half}) ? ({5'd0, shh_q} - {1'b0, half}) : 16'd0;
  assign sum_hb = {5'd0, shh_q} + {1'b0, half};
  assign bot    = (sum_hb > {4'd0, sh_q}) ? {4'd0, sh_q} : sum_hb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sp_vld_q <= 1'b0;
    else         sp_vld_q <= div_vld_q[DIV_BITS];
  end

  always_ff @(posedge clk_i) begin
    sp_pay_q <= div_q[DIV_BITS].pay;
    sp_h_q   <= h;
    sp_in_q  <= ({4'd0, div_q[DIV_BITS].pay.line} >= top) &&
                ({4'd0, div_q[DIV_BITS].pay.line} < bot);
    sp_dft_q <= {6'd0, div_q[DIV_BITS].pay.line} + {3'd0, half} - {7'd0, shh_q};
  end

  // ---------------- texel row divider: dft*TILE / h ----------------
  typedef struct packed {
    pay_t              pay;
    logic              in_wall;
    logic              zero;
    logic              sat;
    logic [H_W-1:0]    h;
    logic [H_W-1:0]    rem;
    logic [TILE_W-1:0] row;
  } row_t;

  logic [ROW_BITS:0] row_vld_q;
  row_t              row_q [ROW_BITS+1];
  logic              dft_pos;
  logic              r_zero;

  assign dft_pos = !sp_dft_q[17] && (sp_dft_q != '0);
  assign r_zero  = (sp_h_q == '0) || !dft_pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) row_vld_q <= '0;
    else         row_vld_q <= {row_vld_q[ROW_BITS-1:0], sp_vld_q};
  end

  // offset of the wall height or more saturates to the last texel row
  always_ff @(posedge clk_i) begin
    row_q[0].pay     <= sp_pay_q;
    row_q[0].in_wall <= sp_in_q;
    row_q[0].zero    <= r_zero;
    row_q[0].sat     <= !r_zero && (sp_dft_q[16:0] >= {1'b0, sp_h_q});
    row_q[0].h       <= sp_h_q;
    row_q[0].rem     <= sp_dft_q[H_W-1:0];
    row_q[0].row     <= '0;
  end

  for (genvar g = 1; g <= ROW_BITS; g++) begin : g_row
    logic [H_W:0] r2;
    logic         ge;
    assign r2 = {row_q[g-1].rem, 1'b0};
    assign ge = r2 >= {1'b0, row_q[g-1].h};
    always_ff @(posedge clk_i) begin
      row_q[g].pay     <= row_q[g-1].pay;
      row_q[g].in_wall <= row_q[g-1].in_wall;
      row_q[g].zero    <= row_q[g-1].zero;
      row_q[g].sat     <= row_q[g-1].sat;
      row_q[g].h       <= row_q[g-1].h;
      row_q[g].rem     <= ge ? H_W'(r2 - {1'b0, row_q[g-1].h}) : r2[H_W-1:0];
      row_q[g].row     <= {row_q[g-1].row[TILE_W-2:0], ge};
    end
  end

  // ---------------- output register ----------------
  logic              out_vld_q;
  logic              out_in_q;
  logic [1:0]        out_face_q;
  logic [TILE_W-1:0] out_col_q;
  logic [TILE_W-1:0] out_row_q;
  logic [DIST_W-1:0] out_dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else         out_vld_q <= row_vld_q[ROW_BITS];
  end

  always_ff @(posedge clk_i) begin
    out_in_q   <= row_q[ROW_BITS].in_wall;
    out_face_q <= row_q[ROW_BITS].pay.face;
    out_col_q  <= row_q[ROW_BITS].pay.col;
    out_dist_q <= row_q[ROW_BITS].pay.cdist;
    if (row_q[ROW_BITS].zero)     out_row_q <= '0;
    else if (row_q[ROW_BITS].sat) out_row_q <= '1;
    else                          out_row_q <= row_q[ROW_BITS].row;
  end

  assign valid_o              = out_vld_q;
  assign in_wall_o            = out_in_q;
  assign wall_face_o          = out_face_q;
  assign texel_column_o       = out_col_q;
  assign texel_row_o          = out_row_q;
  assign corrected_distance_o = out_dist_q;

  // ---------------- assertions ----------------
  `ASSERT_IMP(a_latency, clk_i, rst_ni, valid_o, $past(start_i, LATENCY))
  `ASSERT_NEVER(a_div_rem, clk_i, rst_ni,
    div_vld_q[DIV_BITS] && !div_q[DIV_BITS].ovf &&
    ({(DIST_W+H_W-NUM_W)'(0), div_q[DIV_BITS].rem} >=
     {(H_W)'(0), div_q[DIV_BITS].pay.cdist}))

endmodule
`default_nettype wire
